### src/multilevel_feedback_scheduler_unit_assert.svh
// Assertion macros shared by the scheduler RTL.
`ifndef MULTILEVEL_FEEDBACK_SCHEDULER_UNIT_ASSERT_SVH
`define MULTILEVEL_FEEDBACK_SCHEDULER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define MFSU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define MFSU_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) cond |=> prop) \
        else $error(msg);
`else
`define MFSU_ASSERT(lbl, prop, msg)
`define MFSU_ASSERT_NEXT(lbl, cond, prop, msg)
`endif

`endif

### src/mfs_pkg.sv
`default_nettype none

package mfs_pkg;

    localparam int LEVELS   = 5;
    localparam int CAPACITY = 16;

    localparam int LVL_W    = 3;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ID_W     = 8;
    localparam int NEED_W   = 12;
    localparam int USED_W   = 13;
    localparam int TIME_W   = 32;
    localparam int WAIT_W   = 16;
    localparam int QUANT_W  = 8;
    localparam int STATUS_W = 3;
    localparam int SLICE_OUT_W = 12;
    localparam int SLICE_W  = QUANT_W + LEVELS - 1;
    localparam int SUM_W    = ((SLICE_W > USED_W) ? SLICE_W : USED_W) + 1;

    localparam int MEM_DEPTH = LEVELS * CAPACITY;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    localparam logic [USED_W-1:0]  USED_MAX    = USED_W'(8191);
    localparam logic [WAIT_W-1:0]  WAIT_MAX    = '1;
    localparam logic [QUANT_W-1:0] QUANT_RESET = QUANT_W'(10);
    localparam logic [LVL_W-1:0]   LAST_LEVEL  = LVL_W'(LEVELS - 1);

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_BASE_QUANTUM = 1'b0;

    localparam logic OP_ADD      = 1'b0;
    localparam logic OP_DISPATCH = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED    = 3'd0,
        ST_REJECTED = 3'd1,
        ST_DEMOTED  = 3'd2,
        ST_FINISHED = 3'd3,
        ST_EMPTY    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [NEED_W-1:0] need;
        logic [USED_W-1:0] used;
        logic [TIME_W-1:0] arrival;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] p);
        logic [SLOT_W-1:0] r;
        r = (p == SLOT_W'(CAPACITY - 1)) ? '0 : p + SLOT_W'(1);
        return r;
    endfunction

    function automatic logic [MEM_AW-1:0] mem_addr(input logic [LVL_W-1:0] lvl,
                                                   input logic [SLOT_W-1:0] slot);
        logic [MEM_AW-1:0] a;
        a = MEM_AW'(lvl) * MEM_AW'(CAPACITY) + MEM_AW'(slot);
        return a;
    endfunction

endpackage

`default_nettype wire

### src/multilevel_feedback_scheduler_unit.sv
// Channel  | Ports                                                  | Handshake
// ---------+--------------------------------------------------------+------------------------
// command  | i_op, i_job_id, i_needed_time                          | start high, busy low
// result   | o_status, o_ran_id, o_ran_level, o_slice_given,        | o_done, one cycle
//          | o_next_level, o_wait_total                             |
// config   | psel, penable, pwrite, paddr, pwdata, prdata, pready   | APB write, no wait
//
// An add, a rejected add and a dispatch with nothing queued finish in the idle state.
// A dispatch that runs a job takes three steps: the job memory read, the slice
// arithmetic, and the write back of a demoted job with the wait computation.
// The result is strobed in the cycle after the last step, and the next command can be
// taken at the edge that ends that cycle.
// Reset is synchronous and empties every ring; the job memory needs no clearing.
// The receiver cannot stall the results.
`default_nettype none
`include "multilevel_feedback_scheduler_unit_assert.svh"

module multilevel_feedback_scheduler_unit (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic                                 i_op,
    input  wire logic [mfs_pkg::ID_W-1:0]             i_job_id,
    input  wire logic [mfs_pkg::NEED_W-1:0]           i_needed_time,
    output logic                                      o_done,
    output logic [mfs_pkg::STATUS_W-1:0]              o_status,
    output logic [mfs_pkg::ID_W-1:0]                  o_ran_id,
    output logic [mfs_pkg::LVL_W-1:0]                 o_ran_level,
    output logic [mfs_pkg::SLICE_OUT_W-1:0]           o_slice_given,
    output logic [mfs_pkg::LVL_W-1:0]                 o_next_level,
    output logic [mfs_pkg::WAIT_W-1:0]                o_wait_total,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [mfs_pkg::APB_AW-1:0]           paddr,
    input  wire logic [mfs_pkg::APB_DW-1:0]           pwdata,
    output logic [mfs_pkg::APB_DW-1:0]                prdata,
    output logic                                      pready
);

    mfs_pkg::t_state                    r_state, n_state;
    logic [mfs_pkg::SLOT_W-1:0]         r_head  [mfs_pkg::LEVELS];
    logic [mfs_pkg::SLOT_W-1:0]         n_head  [mfs_pkg::LEVELS];
    logic [mfs_pkg::SLOT_W-1:0]         r_tail  [mfs_pkg::LEVELS];
    logic [mfs_pkg::SLOT_W-1:0]         n_tail  [mfs_pkg::LEVELS];
    logic [mfs_pkg::CNT_W-1:0]          r_count [mfs_pkg::LEVELS];
    logic [mfs_pkg::CNT_W-1:0]          n_count [mfs_pkg::LEVELS];
    logic [mfs_pkg::CNT_W-1:0]          r_jobs, n_jobs;
    logic [mfs_pkg::TIME_W-1:0]         r_elapsed, n_elapsed;
    logic [mfs_pkg::QUANT_W-1:0]        r_quant, n_quant;

    logic [mfs_pkg::LVL_W-1:0]          r_lvl, n_lvl;
    logic [mfs_pkg::LVL_W-1:0]          r_nxt, n_nxt;
    logic                               r_fin, n_fin;
    mfs_pkg::t_entry                    r_entry, n_entry;
    logic [mfs_pkg::TIME_W-1:0]         r_span, n_span;
    logic [mfs_pkg::SLICE_W-1:0]        r_slice, n_slice;

    logic                               r_done, n_done;
    logic [mfs_pkg::STATUS_W-1:0]       r_status, n_status;
    logic [mfs_pkg::ID_W-1:0]           r_ran_id, n_ran_id;
    logic [mfs_pkg::LVL_W-1:0]          r_ran_level, n_ran_level;
    logic [mfs_pkg::SLICE_OUT_W-1:0]    r_slice_given, n_slice_given;
    logic [mfs_pkg::LVL_W-1:0]          r_next_level, n_next_level;
    logic [mfs_pkg::WAIT_W-1:0]         r_wait_total, n_wait_total;

    logic                               w_found;
    logic [mfs_pkg::LVL_W-1:0]          w_pick;
    logic [mfs_pkg::CNT_W+mfs_pkg::LVL_W-1:0] w_count_sum;
    logic                               w_accept;

    logic                               w_wr_en;
    logic [mfs_pkg::MEM_AW-1:0]         w_wr_addr;
    mfs_pkg::t_entry                    w_wr_data;
    logic                               w_rd_en;
    logic [mfs_pkg::MEM_AW-1:0]         w_rd_addr;
    logic [mfs_pkg::ENTRY_W-1:0]        w_rd_data;
    mfs_pkg::t_entry                    w_rd_entry;

    logic [mfs_pkg::SLICE_W-1:0]        w_slice;
    logic [mfs_pkg::SUM_W-1:0]          w_used_sum;
    logic [mfs_pkg::USED_W-1:0]         w_used_new;
    logic [mfs_pkg::TIME_W:0]           w_diff;

    mfs_ram #(
        .WIDTH (mfs_pkg::ENTRY_W),
        .DEPTH (mfs_pkg::MEM_DEPTH)
    ) u_job_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_rd_entry = mfs_pkg::t_entry'(w_rd_data);
    assign busy       = (r_state != mfs_pkg::S_IDLE);
    assign w_accept   = start && !busy;
    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == mfs_pkg::REG_BASE_QUANTUM) ?
                        mfs_pkg::APB_DW'(r_quant) : '0;

    always_comb begin
        w_found     = 1'b0;
        w_pick      = '0;
        w_count_sum = '0;
        for (int i = mfs_pkg::LEVELS - 1; i >= 0; i--) begin
            if (r_count[i] != '0) begin
                w_found = 1'b1;
                w_pick  = mfs_pkg::LVL_W'(i);
            end
            w_count_sum = w_count_sum + (mfs_pkg::CNT_W + mfs_pkg::LVL_W)'(r_count[i]);
        end
    end

    always_comb begin
        w_slice    = mfs_pkg::SLICE_W'(r_quant) << r_lvl;
        w_used_sum = mfs_pkg::SUM_W'(w_rd_entry.used) + mfs_pkg::SUM_W'(w_slice);
        w_used_new = (w_used_sum > mfs_pkg::SUM_W'(mfs_pkg::USED_MAX)) ?
                     mfs_pkg::USED_MAX : mfs_pkg::USED_W'(w_used_sum);
        w_diff     = {1'b0, r_span} - (mfs_pkg::TIME_W + 1)'(r_entry.used);
    end

    always_comb begin
        n_state       = r_state;
        n_head        = r_head;
        n_tail        = r_tail;
        n_count       = r_count;
        n_jobs        = r_jobs;
        n_elapsed     = r_elapsed;
        n_quant       = r_quant;
        n_lvl         = r_lvl;
        n_nxt         = r_nxt;
        n_fin         = r_fin;
        n_entry       = r_entry;
        n_span        = r_span;
        n_slice       = r_slice;
        n_done        = 1'b0;
        n_status      = r_status;
        n_ran_id      = r_ran_id;
        n_ran_level   = r_ran_level;
        n_slice_given = r_slice_given;
        n_next_level  = r_next_level;
        n_wait_total  = r_wait_total;
        w_wr_en       = 1'b0;
        w_wr_addr     = '0;
        w_wr_data     = r_entry;
        w_rd_en       = 1'b0;
        w_rd_addr     = '0;

        if (psel && penable && pwrite && (paddr[2] == mfs_pkg::REG_BASE_QUANTUM)) begin
            n_quant = pwdata[mfs_pkg::QUANT_W-1:0];
        end

        unique case (r_state)
            mfs_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_done        = 1'b1;
                    n_ran_id      = '0;
                    n_ran_level   = '0;
                    n_slice_given = '0;
                    n_next_level  = '0;
                    n_wait_total  = '0;
                    if (i_op == mfs_pkg::OP_ADD) begin
                        n_ran_id = i_job_id;
                        if (r_jobs >= mfs_pkg::CNT_W'(mfs_pkg::CAPACITY)) begin
                            n_status = mfs_pkg::ST_REJECTED;
                        end else begin
                            n_status          = mfs_pkg::ST_ADDED;
                            w_wr_en           = 1'b1;
                            w_wr_addr         = mfs_pkg::mem_addr('0, r_tail[0]);
                            w_wr_data.id      = i_job_id;
                            w_wr_data.need    = i_needed_time;
                            w_wr_data.used    = '0;
                            w_wr_data.arrival = r_elapsed;
                            n_tail[0]         = mfs_pkg::slot_next(r_tail[0]);
                            n_count[0]        = r_count[0] + mfs_pkg::CNT_W'(1);
                            n_jobs            = r_jobs + mfs_pkg::CNT_W'(1);
                        end
                    end else if (!w_found) begin
                        n_status = mfs_pkg::ST_EMPTY;
                    end else begin
                        n_done          = 1'b0;
                        w_rd_en         = 1'b1;
                        w_rd_addr       = mfs_pkg::mem_addr(w_pick, r_head[w_pick]);
                        n_head[w_pick]  = mfs_pkg::slot_next(r_head[w_pick]);
                        n_count[w_pick] = r_count[w_pick] - mfs_pkg::CNT_W'(1);
                        n_lvl           = w_pick;
                        n_state         = mfs_pkg::S_CALC;
                    end
                end
            end
            mfs_pkg::S_CALC: begin
                n_slice      = w_slice;
                n_entry      = w_rd_entry;
                n_entry.used = w_used_new;
                n_elapsed    = r_elapsed + mfs_pkg::TIME_W'(w_slice);
                n_span       = r_elapsed - w_rd_entry.arrival + mfs_pkg::TIME_W'(w_slice);
                n_fin        = (w_used_new >= mfs_pkg::USED_W'(w_rd_entry.need));
                n_nxt        = (r_lvl == mfs_pkg::LAST_LEVEL) ? r_lvl : r_lvl + mfs_pkg::LVL_W'(1);
                n_state      = mfs_pkg::S_FIN;
            end
            mfs_pkg::S_FIN: begin
                n_done        = 1'b1;
                n_ran_id      = r_entry.id;
                n_ran_level   = r_lvl;
                n_slice_given = mfs_pkg::SLICE_OUT_W'(r_slice);
                n_state       = mfs_pkg::S_IDLE;
                if (r_fin) begin
                    n_status     = mfs_pkg::ST_FINISHED;
                    n_next_level = '0;
                    n_jobs       = r_jobs - mfs_pkg::CNT_W'(1);
                    if (w_diff[mfs_pkg::TIME_W]) begin
                        n_wait_total = '0;
                    end else if (|w_diff[mfs_pkg::TIME_W-1:mfs_pkg::WAIT_W]) begin
                        n_wait_total = mfs_pkg::WAIT_MAX;
                    end else begin
                        n_wait_total = w_diff[mfs_pkg::WAIT_W-1:0];
                    end
                end else begin
                    n_status       = mfs_pkg::ST_DEMOTED;
                    n_next_level   = r_nxt;
                    n_wait_total   = '0;
                    w_wr_en        = 1'b1;
                    w_wr_addr      = mfs_pkg::mem_addr(r_nxt, r_tail[r_nxt]);
                    w_wr_data      = r_entry;
                    n_tail[r_nxt]  = mfs_pkg::slot_next(r_tail[r_nxt]);
                    n_count[r_nxt] = r_count[r_nxt] + mfs_pkg::CNT_W'(1);
                end
            end
            default: begin
                n_state = mfs_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mfs_pkg::S_IDLE;
            r_jobs    <= '0;
            r_elapsed <= '0;
            r_quant   <= mfs_pkg::QUANT_RESET;
            r_done    <= 1'b0;
            for (int i = 0; i < mfs_pkg::LEVELS; i++) begin
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_count[i] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_jobs    <= n_jobs;
            r_elapsed <= n_elapsed;
            r_quant   <= n_quant;
            r_done    <= n_done;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lvl         <= n_lvl;
        r_nxt         <= n_nxt;
        r_fin         <= n_fin;
        r_entry       <= n_entry;
        r_span        <= n_span;
        r_slice       <= n_slice;
        r_status      <= n_status;
        r_ran_id      <= n_ran_id;
        r_ran_level   <= n_ran_level;
        r_slice_given <= n_slice_given;
        r_next_level  <= n_next_level;
        r_wait_total  <= n_wait_total;
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_ran_id      = r_ran_id;
    assign o_ran_level   = r_ran_level;
    assign o_slice_given = r_slice_given;
    assign o_next_level  = r_next_level;
    assign o_wait_total  = r_wait_total;

    `MFSU_ASSERT(a_jobs_bound, r_jobs <= mfs_pkg::CNT_W'(mfs_pkg::CAPACITY), "job count overflow")
    `MFSU_ASSERT(a_ring_sum, (r_state == mfs_pkg::S_IDLE) |-> (w_count_sum == (mfs_pkg::CNT_W + mfs_pkg::LVL_W)'(r_jobs)), "ring counts disagree with job count")
    `MFSU_ASSERT_NEXT(a_fin_result, (r_state == mfs_pkg::S_FIN), o_done && ((o_status == mfs_pkg::ST_DEMOTED) || (o_status == mfs_pkg::ST_FINISHED)), "dispatch produced no run transaction")
    `MFSU_ASSERT(a_demote_level, (o_done && (o_status == mfs_pkg::ST_DEMOTED)) |-> ((o_next_level == o_ran_level + mfs_pkg::LVL_W'(1)) || ((o_next_level == o_ran_level) && (o_ran_level == mfs_pkg::LAST_LEVEL))), "demotion to a wrong level")

endmodule

`default_nettype wire

### src/mfs_ram.sv
`default_nettype none

module mfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### bench/tb_multilevel_feedback_scheduler_unit.sv
module tb_multilevel_feedback_scheduler_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT     = 300000;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 70;
    localparam int DIRECTED_ROWS   = 11;
    localparam logic [mfs_pkg::APB_AW-1:0] QUANTUM_ADDR =
        mfs_pkg::APB_AW'(4 * int'(mfs_pkg::REG_BASE_QUANTUM));

    typedef struct packed {
        mfs_pkg::t_status                status;
        logic [mfs_pkg::ID_W-1:0]        ran_id;
        logic [mfs_pkg::LVL_W-1:0]       ran_level;
        logic [mfs_pkg::SLICE_OUT_W-1:0] slice;
        logic [mfs_pkg::LVL_W-1:0]       next_level;
        logic [mfs_pkg::WAIT_W-1:0]      wait_total;
    } t_sched_result;

    typedef struct packed {
        logic                        cfg;
        logic [mfs_pkg::QUANT_W-1:0] quantum;
        logic                        op;
        logic [mfs_pkg::ID_W-1:0]    id;
        logic [mfs_pkg::NEED_W-1:0]  need;
        logic [4:0]                  reps;
        logic                        typed;
        t_sched_result               want;
    } t_stim_row;

    typedef struct packed {
        logic [mfs_pkg::ID_W-1:0]   id;
        logic [mfs_pkg::NEED_W-1:0] need;
        logic [31:0]                used;
        logic [31:0]                arrival;
    } t_job;

    localparam t_sched_result UNCHECKED = '0;

    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            start         = 1'b0;
    logic                            i_op          = mfs_pkg::OP_ADD;
    logic [mfs_pkg::ID_W-1:0]        i_job_id      = '0;
    logic [mfs_pkg::NEED_W-1:0]      i_needed_time = '0;
    logic                            psel          = 1'b0;
    logic                            penable       = 1'b0;
    logic                            pwrite        = 1'b0;
    logic [mfs_pkg::APB_AW-1:0]      paddr         = '0;
    logic [mfs_pkg::APB_DW-1:0]      pwdata        = '0;
    logic                            busy;
    logic                            o_done;
    logic [mfs_pkg::STATUS_W-1:0]    o_status;
    logic [mfs_pkg::ID_W-1:0]        o_ran_id;
    logic [mfs_pkg::LVL_W-1:0]       o_ran_level;
    logic [mfs_pkg::SLICE_OUT_W-1:0] o_slice_given;
    logic [mfs_pkg::LVL_W-1:0]       o_next_level;
    logic [mfs_pkg::WAIT_W-1:0]      o_wait_total;
    logic [mfs_pkg::APB_DW-1:0]      prdata;
    logic                            pready;

    t_job         job_ring [mfs_pkg::LEVELS][mfs_pkg::CAPACITY];
    int           ring_rd [mfs_pkg::LEVELS]   = '{default: 0};
    int           ring_wr [mfs_pkg::LEVELS]   = '{default: 0};
    int           ring_fill [mfs_pkg::LEVELS] = '{default: 0};
    int           jobs_held          = 0;
    logic [31:0]  clock_elapsed      = '0;
    logic [mfs_pkg::QUANT_W-1:0] quantum = mfs_pkg::QUANT_RESET;

    t_sched_result expected_results [$];
    t_sched_result seen_result;
    t_sched_result oldest_result;
    int           fail_count  = 0;
    int           cycle_count = 0;

    t_stim_row stim_rows [DIRECTED_ROWS] = '{
        '{1'b0, 8'd0, mfs_pkg::OP_DISPATCH, 8'h00, 12'h000, 5'd1, 1'b1,
          '{mfs_pkg::ST_EMPTY, 8'h00, 3'd0, 12'd0, 3'd0, 16'd0}},
        '{1'b0, 8'd0, mfs_pkg::OP_ADD, 8'hFF, 12'hFFF, 5'd1, 1'b1,
          '{mfs_pkg::ST_ADDED, 8'hFF, 3'd0, 12'd0, 3'd0, 16'd0}},
        '{1'b0, 8'd0, mfs_pkg::OP_ADD, 8'h00, 12'h000, 5'd1, 1'b1,
          '{mfs_pkg::ST_ADDED, 8'h00, 3'd0, 12'd0, 3'd0, 16'd0}},
        '{1'b0, 8'd0, mfs_pkg::OP_DISPATCH, 8'h00, 12'h000, 5'd1, 1'b1,
          '{mfs_pkg::ST_DEMOTED, 8'hFF, 3'd0, 12'd10, 3'd1, 16'd0}},
        '{1'b0, 8'd0, mfs_pkg::OP_DISPATCH, 8'h00, 12'h000, 5'd1, 1'b0, UNCHECKED},
        '{1'b0, 8'd0, mfs_pkg::OP_ADD, 8'h40, 12'h000, 5'd15, 1'b0, UNCHECKED},
        '{1'b0, 8'd0, mfs_pkg::OP_ADD, 8'hAA, 12'h123, 5'd1, 1'b1,
          '{mfs_pkg::ST_REJECTED, 8'hAA, 3'd0, 12'd0, 3'd0, 16'd0}},
        '{1'b1, 8'd0, mfs_pkg::OP_ADD, 8'h00, 12'h000, 5'd0, 1'b0, UNCHECKED},
        '{1'b0, 8'd0, mfs_pkg::OP_DISPATCH, 8'h00, 12'h000, 5'd1, 1'b0, UNCHECKED},
        '{1'b1, 8'd255, mfs_pkg::OP_ADD, 8'h00, 12'h000, 5'd0, 1'b0, UNCHECKED},
        '{1'b0, 8'd0, mfs_pkg::OP_DISPATCH, 8'h00, 12'h000, 5'd2, 1'b0, UNCHECKED}
    };

    multilevel_feedback_scheduler_unit dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic void push_job(input int lvl, input t_job j);
        job_ring[lvl][ring_wr[lvl]] = j;
        ring_wr[lvl] = (ring_wr[lvl] + 1 >= mfs_pkg::CAPACITY) ? 0 : ring_wr[lvl] + 1;
        ring_fill[lvl]++;
    endfunction

    function automatic t_sched_result schedule_step(input logic op,
                                                    input logic [mfs_pkg::ID_W-1:0] id,
                                                    input logic [mfs_pkg::NEED_W-1:0] need);
        t_sched_result r;
        t_job          j;
        int            lvl;
        int            nxt;
        logic [31:0]   slice;
        logic [31:0]   span;
        logic [31:0]   waited;
        r = UNCHECKED;
        if (op == mfs_pkg::OP_ADD) begin
            r.ran_id = id;
            if (jobs_held >= mfs_pkg::CAPACITY) begin
                r.status = mfs_pkg::ST_REJECTED;
                return r;
            end
            j.id      = id;
            j.need    = need;
            j.used    = '0;
            j.arrival = clock_elapsed;
            push_job(0, j);
            jobs_held++;
            r.status = mfs_pkg::ST_ADDED;
            return r;
        end
        lvl = 0;
        while (lvl < mfs_pkg::LEVELS && ring_fill[lvl] == 0) lvl++;
        if (lvl >= mfs_pkg::LEVELS) begin
            r.status = mfs_pkg::ST_EMPTY;
            return r;
        end
        j = job_ring[lvl][ring_rd[lvl]];
        ring_rd[lvl] = (ring_rd[lvl] + 1 >= mfs_pkg::CAPACITY) ? 0 : ring_rd[lvl] + 1;
        ring_fill[lvl]--;
        slice = 32'(quantum) << lvl;
        j.used = j.used + slice;
        if (j.used > 32'(mfs_pkg::USED_MAX)) j.used = 32'(mfs_pkg::USED_MAX);
        clock_elapsed = clock_elapsed + slice;
        r.ran_id    = j.id;
        r.ran_level = mfs_pkg::LVL_W'(lvl);
        r.slice     = mfs_pkg::SLICE_OUT_W'(slice);
        if (j.used >= 32'(j.need)) begin
            span   = clock_elapsed - j.arrival;
            waited = (span < j.used) ? 32'd0 : span - j.used;
            if (waited > 32'(mfs_pkg::WAIT_MAX)) waited = 32'(mfs_pkg::WAIT_MAX);
            jobs_held--;
            r.status     = mfs_pkg::ST_FINISHED;
            r.wait_total = mfs_pkg::WAIT_W'(waited);
            return r;
        end
        nxt = (lvl + 1 < mfs_pkg::LEVELS) ? lvl + 1 : lvl;
        push_job(nxt, j);
        r.status     = mfs_pkg::ST_DEMOTED;
        r.next_level = mfs_pkg::LVL_W'(nxt);
        return r;
    endfunction

    function automatic string fmt_result(input t_sched_result r);
        return $sformatf("status %0d id %02h level %0d slice %0d next %0d wait %0d",
                         r.status, r.ran_id, r.ran_level, r.slice, r.next_level,
                         r.wait_total);
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("%s", msg);
    endfunction

    task automatic issue_item(input logic op, input logic [mfs_pkg::ID_W-1:0] id,
                              input logic [mfs_pkg::NEED_W-1:0] need, input logic typed,
                              input t_sched_result typed_want, input int idle_pct,
                              input bit last_one);
        t_sched_result predicted;
        bit            hold_off;
        start         <= 1'b1;
        i_op          <= op;
        i_job_id      <= id;
        i_needed_time <= need;
        do @(posedge i_clk); while (busy);
        predicted = schedule_step(op, id, need);
        expected_results.push_back(typed ? typed_want : predicted);
        hold_off = ($urandom_range(0, 99) < idle_pct);
        if (hold_off || last_one) start <= 1'b0;
        if (hold_off) repeat ($urandom_range(1, 19)) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [mfs_pkg::APB_DW-1:0] data,
                              output logic [mfs_pkg::APB_DW-1:0] rd);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= QUANTUM_ADDR;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // The register is only written once every outstanding transaction has returned.
    task automatic set_quantum(input logic [mfs_pkg::QUANT_W-1:0] value);
        logic [mfs_pkg::APB_DW-1:0] rd;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        apb_access(1'b1, {24'($urandom), value}, rd);
        quantum = value;
        @(posedge i_clk);
        apb_access(1'b0, '0, rd);
        if (rd[mfs_pkg::QUANT_W-1:0] !== value)
            note_failure($sformatf("quantum readback: expected %0d got %0d", value,
                                   rd[mfs_pkg::QUANT_W-1:0]));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            seen_result.status     = mfs_pkg::t_status'(o_status);
            seen_result.ran_id     = o_ran_id;
            seen_result.ran_level  = o_ran_level;
            seen_result.slice      = o_slice_given;
            seen_result.next_level = o_next_level;
            seen_result.wait_total = o_wait_total;
            if (expected_results.size() == 0) begin
                note_failure({"unexpected transaction: ", fmt_result(seen_result)});
            end else begin
                oldest_result = expected_results.pop_front();
                if (seen_result !== oldest_result)
                    note_failure({"mismatch: expected ", fmt_result(oldest_result),
                                  " got ", fmt_result(seen_result)});
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        logic [mfs_pkg::QUANT_W-1:0] q;
        logic                        op;
        logic [mfs_pkg::NEED_W-1:0]  need;
        int                          add_pct;
        int                          idle_pct;
        bit                          last_one;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_rows[r]) begin
            if (stim_rows[r].cfg) begin
                set_quantum(stim_rows[r].quantum);
            end else begin
                for (int k = 0; k < int'(stim_rows[r].reps); k++) begin
                    last_one = (k == int'(stim_rows[r].reps) - 1);
                    if (last_one && r != DIRECTED_ROWS - 1) last_one = stim_rows[r + 1].cfg;
                    issue_item(stim_rows[r].op, stim_rows[r].id + mfs_pkg::ID_W'(k),
                               stim_rows[r].need, stim_rows[r].typed, stim_rows[r].want,
                               20, last_one);
                end
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p % 5)
                0: q = 8'd255;
                1: q = 8'd1;
                3: q = 8'd0;
                default: q = mfs_pkg::QUANT_W'($urandom_range(1, 254));
            endcase
            set_quantum(q);
            add_pct  = $urandom_range(15, 85);
            idle_pct = (p == PHASES - 1) ? 0 : $urandom_range(0, 40);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                op = ($urandom_range(0, 99) < add_pct) ? mfs_pkg::OP_ADD : mfs_pkg::OP_DISPATCH;
                case ($urandom_range(0, 3))
                    0: need = mfs_pkg::NEED_W'($urandom_range(0, 15));
                    1: need = mfs_pkg::NEED_W'(4095 - $urandom_range(0, 15));
                    default: need = mfs_pkg::NEED_W'($urandom);
                endcase
                issue_item(op, mfs_pkg::ID_W'($urandom), need, 1'b0, UNCHECKED, idle_pct,
                           n == ITEMS_PER_PHASE - 1);
            end
        end

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
